FILE: design/cjt_pkg.sv
// ============================================================================
// cjt_pkg
// Shared types and constants of the cubic joint trajectory generator.
// ============================================================================
package cjt_pkg;

   localparam int JOINTS      = 64;
   localparam int MAX_SAMPLES = 64;
   localparam int NUM_W       = 64;
   localparam int DIV_W       = 22;
   localparam int QB          = 33;
   localparam int R_W         = DIV_W + QB;
   localparam int LANES       = 3;

   localparam logic [7:0] FINAL_TIME_RESET     = 8'd5;
   localparam logic [6:0] WAYPOINT_COUNT_RESET = 7'd10;

   localparam logic REG_FINAL_TIME     = 1'b0;
   localparam logic REG_WAYPOINT_COUNT = 1'b1;

   localparam int LANE_POS = 0;
   localparam int LANE_VEL = 1;
   localparam int LANE_ACC = 2;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SETUP1,
      ST_SETUP2,
      ST_SETUP3,
      ST_ISSUE
   } state_type;

   typedef struct packed {
      logic [5:0] joint;
      logic [5:0] idx;
      logic       last;
   } tag_type;

   typedef logic [LANES-1:0][DIV_W-1:0] divs_type;

endpackage

FILE: design/cubic_joint_trajectory.sv
// ============================================================================
// cubic_joint_trajectory
// Cubic joint trajectory generator: fits a cubic per joint and emits samples.
// ============================================================================
// Usage:
//   Input: an item (joint id, start/end position and velocity, Q16.16) is
//   taken at a rising edge with start high and busy low. busy stays high
//   through the setup states SETUP1, SETUP2 and SETUP3 and the issue
//   state, in which the N samples are issued, N = waypoint_count clamped
//   to 2..64; no new item is taken until the last sample has issued.
//   Output: N samples in consecutive cycles, k ascending, each marked by a
//   one-cycle rsp_valid strobe, rsp_last on the final one.
//   Each sample passes a multiply pipeline and a 33-stage radix-2 divider
//   pipeline, one sample per cycle. Results cannot be held off: the
//   receiver must take every strobe.
//   Configuration: APB port, final_time at 0x0, waypoint_count at 0x4;
//   write only while idle. pready is always high.
//   Reset: synchronous, clears the sequencer and all valid bits, and loads
//   final_time = 5 and waypoint_count = 10.
// ============================================================================
module cubic_joint_trajectory
   import cjt_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic [5:0]         req_joint_id,
   input  logic signed [31:0] req_start_position,
   input  logic signed [31:0] req_end_position,
   input  logic signed [31:0] req_start_velocity,
   input  logic signed [31:0] req_end_velocity,
   output logic               rsp_valid,
   output logic [5:0]         rsp_joint_out,
   output logic [5:0]         rsp_sample_index,
   output logic signed [31:0] rsp_position,
   output logic signed [31:0] rsp_velocity,
   output logic signed [31:0] rsp_acceleration,
   output logic               rsp_last,
   input  logic               psel,
   input  logic               penable,
   input  logic               pwrite,
   input  logic [2:0]         paddr,
   input  logic [31:0]        pwdata,
   output logic [31:0]        prdata,
   output logic               pready
);

   // configuration registers
   logic [7:0] final_time_ff;
   logic [6:0] waypoint_count_ff;
   logic       csr_write;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite;

   always_ff @(posedge clock) begin
      if (reset) begin
         final_time_ff     <= FINAL_TIME_RESET;
         waypoint_count_ff <= WAYPOINT_COUNT_RESET;
      end else if (csr_write) begin
         case (paddr[2])
            REG_FINAL_TIME:     final_time_ff     <= pwdata[7:0];
            REG_WAYPOINT_COUNT: waypoint_count_ff <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (paddr[2])
         REG_FINAL_TIME:     prdata = {24'd0, final_time_ff};
         REG_WAYPOINT_COUNT: prdata = {25'd0, waypoint_count_ff};
         default:            prdata = 32'd0;
      endcase
   end

   // sequencer
   state_type  state_ff, state_in;
   logic [5:0] k_ff, k_in;
   logic       accept, issue;
   logic       joint_ok;

   assign busy     = (state_ff != ST_IDLE);
   assign accept   = start & ~busy;
   assign joint_ok = (7'(req_joint_id) < 7'(JOINTS));

   logic [5:0] joint_ff;
   logic signed [31:0] p0_ff, p1_ff, v0_ff, v1_ff;
   logic [7:0] t_ff;
   logic [5:0] d_ff;
   logic [5:0] d_clamp;

   always_comb begin
      if (waypoint_count_ff < 7'd2) begin
         d_clamp = 6'd1;
      end else if (waypoint_count_ff > 7'(MAX_SAMPLES)) begin
         d_clamp = 6'(MAX_SAMPLES - 1);
      end else begin
         d_clamp = 6'(waypoint_count_ff - 7'd1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= 6'd0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      k_in     = k_ff;
      issue    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            k_in = 6'd0;
            if (accept && joint_ok) begin
               state_in = ST_SETUP1;
            end
         end
         ST_SETUP1: state_in = ST_SETUP2;
         ST_SETUP2: state_in = ST_SETUP3;
         ST_SETUP3: state_in = ST_ISSUE;
         ST_ISSUE: begin
            issue = 1'b1;
            k_in  = 6'(k_ff + 6'd1);
            if (k_ff == d_ff) begin
               state_in = ST_IDLE;
               k_in     = 6'd0;
            end
         end
         default: begin
            state_in = ST_IDLE;
            k_in     = 6'd0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         joint_ff <= req_joint_id;
         p0_ff    <= req_start_position;
         p1_ff    <= req_end_position;
         v0_ff    <= req_start_velocity;
         v1_ff    <= req_end_velocity;
         t_ff     <= (final_time_ff == 8'd0) ? 8'd1 : final_time_ff;
         d_ff     <= d_clamp;
      end
   end

   // per-item coefficients
   logic signed [8:0]  ts_w;
   logic signed [32:0] h_in, h_ff, s1_w;
   logic signed [33:0] s2_w;
   logic signed [40:0] vt_in, vt_ff;
   logic signed [42:0] sa_in, sa_ff;
   logic signed [41:0] sq_in, sq_ff;
   logic [11:0]        d2_in, d2_ff;
   logic signed [44:0] a_in, a_ff;
   logic signed [43:0] b_in, b_ff;
   logic [17:0]        d3_in, d3_ff;
   logic [19:0]        dv_in, dv_ff;
   logic [15:0]        tt_in, tt_ff;
   logic signed [50:0] p0d3_in, p0d3_ff;
   logic signed [53:0] vtd2_in, vtd2_ff;
   logic signed [51:0] ad_in, ad_ff;
   logic [21:0]        da_in, da_ff;

   assign ts_w  = $signed({1'b0, t_ff});
   assign h_in  = 33'(p1_ff) - 33'(p0_ff);
   assign s2_w  = 34'(v0_ff) + 34'(v0_ff) + 34'(v1_ff);
   assign s1_w  = 33'(v0_ff) + 33'(v1_ff);
   assign vt_in = v0_ff * ts_w;
   assign sa_in = s2_w * ts_w;
   assign sq_in = s1_w * ts_w;
   assign d2_in = d_ff * d_ff;

   assign a_in  = 45'(h_ff) + 45'(h_ff) + 45'(h_ff) - 45'(sa_ff);
   assign b_in  = 44'(sq_ff) - 44'(h_ff) - 44'(h_ff);
   assign d3_in = d2_ff * d_ff;
   assign dv_in = t_ff * d2_ff;
   assign tt_in = t_ff * t_ff;

   assign p0d3_in = p0_ff * $signed({1'b0, d3_ff});
   assign vtd2_in = vt_ff * $signed({1'b0, d2_ff});
   assign ad_in   = a_ff * $signed({1'b0, d_ff});
   assign da_in   = tt_ff * d_ff;

   always_ff @(posedge clock) begin
      h_ff    <= h_in;
      vt_ff   <= vt_in;
      sa_ff   <= sa_in;
      sq_ff   <= sq_in;
      d2_ff   <= d2_in;
      a_ff    <= a_in;
      b_ff    <= b_in;
      d3_ff   <= d3_in;
      dv_ff   <= dv_in;
      tt_ff   <= tt_in;
      p0d3_ff <= p0d3_in;
      vtd2_ff <= vtd2_in;
      ad_ff   <= ad_in;
      da_ff   <= da_in;
   end

   // sample stage 1: index and copies
   logic               v1s_ff;
   tag_type            tag1_ff;
   divs_type           div1_ff;
   logic signed [6:0]  k1_ff;
   logic signed [12:0] kk1_ff;
   logic [11:0]        kk_w;
   logic signed [50:0] p0d3_1_ff;
   logic signed [53:0] vtd2_1_ff;
   logic signed [51:0] ad_1_ff;
   logic signed [43:0] b_1_ff;

   assign kk_w = k_ff * k_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1s_ff <= 1'b0;
      end else begin
         v1s_ff <= issue;
      end
      tag1_ff.joint      <= joint_ff;
      tag1_ff.idx        <= k_ff;
      tag1_ff.last       <= (k_ff == d_ff);
      div1_ff[LANE_POS]  <= DIV_W'(d3_ff);
      div1_ff[LANE_VEL]  <= DIV_W'(dv_ff);
      div1_ff[LANE_ACC]  <= da_ff;
      k1_ff              <= $signed({1'b0, k_ff});
      kk1_ff             <= $signed({1'b0, kk_w});
      p0d3_1_ff          <= p0d3_ff;
      vtd2_1_ff          <= vtd2_ff;
      ad_1_ff            <= ad_ff;
      b_1_ff             <= b_ff;
   end

   // sample stage 2: first products
   logic               v2s_ff;
   tag_type            tag2_ff;
   divs_type           div2_ff;
   logic signed [19:0] k3_in, k3_2_ff;
   logic signed [60:0] pk_in, pk_2_ff;
   logic signed [64:0] pa_w;
   logic signed [63:0] pa_2_ff;
   logic signed [58:0] vk_in, vk_2_ff;
   logic signed [56:0] vb_in, vb_2_ff;
   logic signed [50:0] ab_in, ab_2_ff;
   logic signed [50:0] p0d3_2_ff;
   logic signed [53:0] vtd2_2_ff;
   logic signed [51:0] ad_2_ff;
   logic signed [43:0] b_2_ff;

   assign k3_in = kk1_ff * k1_ff;
   assign pk_in = vtd2_1_ff * k1_ff;
   assign pa_w  = ad_1_ff * kk1_ff;
   assign vk_in = ad_1_ff * k1_ff;
   assign vb_in = b_1_ff * kk1_ff;
   assign ab_in = b_1_ff * k1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2s_ff <= 1'b0;
      end else begin
         v2s_ff <= v1s_ff;
      end
      tag2_ff   <= tag1_ff;
      div2_ff   <= div1_ff;
      k3_2_ff   <= k3_in;
      pk_2_ff   <= pk_in;
      pa_2_ff   <= NUM_W'(pa_w);
      vk_2_ff   <= vk_in;
      vb_2_ff   <= vb_in;
      ab_2_ff   <= ab_in;
      p0d3_2_ff <= p0d3_1_ff;
      vtd2_2_ff <= vtd2_1_ff;
      ad_2_ff   <= ad_1_ff;
      b_2_ff    <= b_1_ff;
   end

   // sample stage 3: cubic term and partial sums
   logic               v3s_ff;
   tag_type            tag3_ff;
   divs_type           div3_ff;
   logic signed [63:0] pb_in, pb_3_ff;
   logic signed [63:0] pp_in, pp_3_ff;
   logic signed [63:0] vn_in, vn_3_ff;
   logic signed [63:0] an_in, an_3_ff;
   logic signed [63:0] vk_x, vb_x, ab_x;

   assign pb_in = b_2_ff * k3_2_ff;
   assign pp_in = NUM_W'(p0d3_2_ff) + NUM_W'(pk_2_ff) + pa_2_ff;
   assign vk_x  = NUM_W'(vk_2_ff);
   assign vb_x  = NUM_W'(vb_2_ff);
   assign ab_x  = NUM_W'(ab_2_ff);
   assign vn_in = NUM_W'(vtd2_2_ff) + (vk_x <<< 1) + vb_x + (vb_x <<< 1);
   assign an_in = (NUM_W'(ad_2_ff) <<< 1) + (ab_x <<< 1) + (ab_x <<< 2);

   always_ff @(posedge clock) begin
      if (reset) begin
         v3s_ff <= 1'b0;
      end else begin
         v3s_ff <= v2s_ff;
      end
      tag3_ff <= tag2_ff;
      div3_ff <= div2_ff;
      pb_3_ff <= pb_in;
      pp_3_ff <= pp_in;
      vn_3_ff <= vn_in;
      an_3_ff <= an_in;
   end

   // sample stage 4: numerators
   logic               v4s_ff;
   tag_type            tag4_ff;
   divs_type           div4_ff;
   logic signed [63:0] num4_ff [LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         v4s_ff <= 1'b0;
      end else begin
         v4s_ff <= v3s_ff;
      end
      tag4_ff            <= tag3_ff;
      div4_ff            <= div3_ff;
      num4_ff[LANE_POS]  <= pp_3_ff + pb_3_ff;
      num4_ff[LANE_VEL]  <= vn_3_ff;
      num4_ff[LANE_ACC]  <= an_3_ff;
   end

   // divider pipeline: entry 0 is the rounding and range check
   logic           dvalid_ff [QB+1];
   tag_type        dtag_ff   [QB+1];
   divs_type       ddiv_ff   [QB+1];
   logic [R_W-1:0] rem_ff    [QB+1][LANES];
   logic [R_W-1:0] rem_in    [QB+1][LANES];
   logic [QB-1:0]  quo_ff    [QB+1][LANES];
   logic [QB-1:0]  quo_in    [QB+1][LANES];
   logic           neg_ff    [QB+1][LANES];
   logic           ovf_ff    [QB+1][LANES];
   logic           neg_in    [LANES];
   logic           ovf_in    [LANES];

   always_comb begin
      logic [NUM_W-1:0] mag;
      logic [NUM_W-1:0] lim;
      logic [R_W-1:0]   sh;
      logic             bit_q;
      for (int l = 0; l < LANES; l++) begin
         neg_in[l] = num4_ff[l][NUM_W-1];
         mag = neg_in[l] ? NUM_W'(-num4_ff[l]) : NUM_W'(num4_ff[l]);
         mag = mag + NUM_W'(div4_ff[l] >> 1);
         lim = NUM_W'({div4_ff[l], {QB{1'b0}}});
         ovf_in[l]    = (mag >= lim);
         rem_in[0][l] = ovf_in[l] ? '0 : mag[R_W-1:0];
         quo_in[0][l] = '0;
      end
      for (int j = 0; j < QB; j++) begin
         for (int l = 0; l < LANES; l++) begin
            sh    = R_W'(ddiv_ff[j][l]) << (QB - 1 - j);
            bit_q = (rem_ff[j][l] >= sh);
            rem_in[j+1][l] = bit_q ? (rem_ff[j][l] - sh) : rem_ff[j][l];
            quo_in[j+1][l] = {quo_ff[j][l][QB-2:0], bit_q};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j <= QB; j++) begin
            dvalid_ff[j] <= 1'b0;
         end
      end else begin
         dvalid_ff[0] <= v4s_ff;
         for (int j = 0; j < QB; j++) begin
            dvalid_ff[j+1] <= dvalid_ff[j];
         end
      end
      dtag_ff[0] <= tag4_ff;
      ddiv_ff[0] <= div4_ff;
      for (int l = 0; l < LANES; l++) begin
         rem_ff[0][l] <= rem_in[0][l];
         quo_ff[0][l] <= quo_in[0][l];
         neg_ff[0][l] <= neg_in[l];
         ovf_ff[0][l] <= ovf_in[l];
      end
      for (int j = 0; j < QB; j++) begin
         dtag_ff[j+1] <= dtag_ff[j];
         ddiv_ff[j+1] <= ddiv_ff[j];
         for (int l = 0; l < LANES; l++) begin
            rem_ff[j+1][l] <= rem_in[j+1][l];
            quo_ff[j+1][l] <= quo_in[j+1][l];
            neg_ff[j+1][l] <= neg_ff[j][l];
            ovf_ff[j+1][l] <= ovf_ff[j][l];
         end
      end
   end

   // sign and saturation
   logic [31:0] res_w [LANES];

   always_comb begin
      logic [QB-1:0] q;
      for (int l = 0; l < LANES; l++) begin
         q = quo_ff[QB][l];
         if (ovf_ff[QB][l]) begin
            res_w[l] = neg_ff[QB][l] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         end else if (!neg_ff[QB][l]) begin
            res_w[l] = (q > QB'(33'h0_7FFF_FFFF)) ? 32'h7FFF_FFFF : q[31:0];
         end else begin
            res_w[l] = (q > QB'(33'h0_8000_0000)) ? 32'h8000_0000
                                                    : 32'(QB'(0) - q);
         end
      end
   end

   logic        rsp_valid_ff;
   tag_type     rsp_tag_ff;
   logic [31:0] rsp_pos_ff, rsp_vel_ff, rsp_acc_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= dvalid_ff[QB];
      end
      rsp_tag_ff <= dtag_ff[QB];
      rsp_pos_ff <= res_w[LANE_POS];
      rsp_vel_ff <= res_w[LANE_VEL];
      rsp_acc_ff <= res_w[LANE_ACC];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_joint_out    = rsp_tag_ff.joint;
   assign rsp_sample_index = rsp_tag_ff.idx;
   assign rsp_last         = rsp_tag_ff.last;
   assign rsp_position     = $signed(rsp_pos_ff);
   assign rsp_velocity     = $signed(rsp_vel_ff);
   assign rsp_acceleration = $signed(rsp_acc_ff);

`ifndef SYNTH
   a_issue_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (k_ff <= d_ff))
      else $error("issue index beyond last sample");

   a_samples_contiguous: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |=>
         (rsp_valid && rsp_sample_index == 6'($past(rsp_sample_index) + 6'd1)))
      else $error("samples of one joint not contiguous");

   a_first_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !$past(rsp_valid && !rsp_last)) |-> (rsp_sample_index == 6'd0))
      else $error("joint does not start at sample zero");
`endif

endmodule
